@@ rtl/ars_pkg.sv @@
`default_nettype none
package ars_pkg;

	localparam int SLOTS       = 4;
	localparam int MAX_PAYLOAD = 8;
	localparam int STAGE_DEPTH = 8;

	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int STAGE_W    = $clog2(STAGE_DEPTH);
	localparam int PAY_IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int PAY_ADDR_W = (SLOTS * MAX_PAYLOAD > 1) ? $clog2(SLOTS * MAX_PAYLOAD) : 1;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = 4;
	localparam int HDR_BYTES  = 5;

	typedef logic [2:0] action_t;
	localparam action_t ACT_STAGE    = 3'd0;
	localparam action_t ACT_SEND     = 3'd1;
	localparam action_t ACT_TICK     = 3'd2;
	localparam action_t ACT_RX       = 3'd3;
	localparam action_t ACT_ANNOUNCE = 3'd4;

	typedef logic [1:0] ftype_t;
	localparam ftype_t FT_DATA     = 2'd0;
	localparam ftype_t FT_ACK      = 2'd1;
	localparam ftype_t FT_DISCOVER = 2'd2;
	localparam ftype_t FT_OFFER    = 2'd3;

	typedef logic [2:0] event_t;
	localparam event_t EV_BYTE   = 3'd0;
	localparam event_t EV_ACCEPT = 3'd1;
	localparam event_t EV_REFUSE = 3'd2;
	localparam event_t EV_ACKED  = 3'd3;
	localparam event_t EV_GIVEUP = 3'd4;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_OWN_ADDR  = 3'd0;
	localparam reg_idx_t REG_GATEWAY   = 3'd1;
	localparam reg_idx_t REG_BCAST     = 3'd2;
	localparam reg_idx_t REG_TIMEOUT   = 3'd3;
	localparam reg_idx_t REG_RETRY_LIM = 3'd4;

	typedef struct packed {
		logic [7:0]       dest;
		logic [7:0]       seq;
		logic [LEN_W-1:0] len;
		logic [31:0]      stamp;
		logic [3:0]       tries;
	} slot_meta_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_meta_t        data;
	} meta_wr_t;

	typedef struct packed {
		logic                  en;
		logic [PAY_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} pay_wr_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [1:0] slot;
		logic       frame_end;
	} result_t;

	function automatic logic [PAY_ADDR_W-1:0] pay_addr(input logic [SLOT_W-1:0] slot,
			input logic [PAY_IDX_W-1:0] idx);
		pay_addr = PAY_ADDR_W'(PAY_ADDR_W'(slot) * PAY_ADDR_W'(MAX_PAYLOAD))
			+ PAY_ADDR_W'(idx);
	endfunction

endpackage
`default_nettype wire

@@ rtl/ars_meta_ram.sv @@
`default_nettype none
module ars_meta_ram import ars_pkg::*; (
	input  wire               clk,
	input  meta_wr_t          wr,
	input  wire  [SLOT_W-1:0] raddr,
	output slot_meta_t        rdata
);

	slot_meta_t mem [SLOTS];
	slot_meta_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/ars_pay_ram.sv @@
`default_nettype none
module ars_pay_ram import ars_pkg::*; (
	input  wire                   clk,
	input  pay_wr_t               wr,
	input  wire  [PAY_ADDR_W-1:0] raddr,
	output logic [7:0]            rdata
);

	logic [7:0] mem [SLOTS * MAX_PAYLOAD];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/ars_ctrl.sv @@
`default_nettype none
module ars_ctrl import ars_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [2:0]            in_action,
	input  wire  [7:0]            in_dest,
	input  wire  [7:0]            in_source,
	input  wire  [1:0]            in_kind,
	input  wire  [7:0]            in_seq,
	input  wire  [7:0]            in_len,
	input  wire  [7:0]            in_byte,
	input  wire  [2:0]            in_stage_idx,
	input  wire  [31:0]           in_now,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [2:0]            cfg_index,
	input  wire  [15:0]           cfg_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output result_t               out_res,
	output logic                  out_last,
	output meta_wr_t              meta_wr,
	output logic [SLOT_W-1:0]     meta_raddr,
	input  slot_meta_t            meta_rdata,
	output pay_wr_t               pay_wr,
	output logic [PAY_ADDR_W-1:0] pay_raddr,
	input  wire  [7:0]            pay_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_META_RD, ST_META_CHK, ST_FRAME, ST_EVENT, ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {SRC_STAGE, SRC_RAM, SRC_OWN} src_t;

	state_t            state_q;
	logic [7:0]        own_addr_q;
	logic              gateway_q;
	logic [7:0]        bcast_q;
	logic [15:0]       timeout_q;
	logic [3:0]        retry_lim_q;
	logic [7:0]        next_seq_q;
	logic [SLOTS-1:0]  valid_q;
	logic [SLOT_W-1:0] s_q;
	logic              walk_ack_q;
	logic [CNT_W-1:0]  k_q;
	logic [7:0]        f_dst_q;
	ftype_t            f_type_q;
	logic [7:0]        f_seq_q;
	logic [LEN_W-1:0]  f_len_q;
	logic [SLOT_W-1:0] f_slot_q;
	src_t              f_src_q;
	logic              post_ev_q;
	logic              walk_q;
	event_t            ev_q;
	logic [SLOT_W-1:0] ev_slot_q;
	logic [31:0]       now_q;
	logic [7:0]        rx_seq_q;
	logic              pend_v_q;
	result_t           pend_q;
	logic              out_v_q;
	result_t           out_q;
	logic              out_last_q;
	logic [7:0]        stage_q [STAGE_DEPTH];

	logic              in_fire;
	logic              out_room;
	logic              gen_fire;
	logic              push;
	result_t           gen_res;
	logic [7:0]        fbyte;
	logic              fend;
	logic [CNT_W-1:0]  k_nxt;
	logic [CNT_W-1:0]  pidx;
	logic [CNT_W-1:0]  pidx_nxt;
	logic              any_free;
	logic [SLOT_W-1:0] free_slot;
	logic [LEN_W-1:0]  len_sat;
	logic [31:0]       elapsed;
	logic              timed_out;
	logic              mine;
	logic              last_slot;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_room  = !out_v_q || out_ready;
	assign gen_fire  = ((state_q == ST_FRAME) || (state_q == ST_EVENT))
		&& (!pend_v_q || out_room);
	assign push      = pend_v_q && (gen_fire || ((state_q == ST_FLUSH) && out_room));

	always_comb begin
		any_free  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	assign len_sat   = (in_len > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len[LEN_W-1:0];
	assign elapsed   = now_q - meta_rdata.stamp;
	assign timed_out = elapsed > {16'd0, timeout_q};
	assign mine      = (in_dest == own_addr_q) || (in_dest == bcast_q);
	assign last_slot = (s_q == SLOT_W'(SLOTS - 1));

	// The payload memory is addressed with the byte that will be on show next cycle.
	assign k_nxt     = gen_fire ? k_q + CNT_W'(1) : k_q;
	assign pidx      = k_q - CNT_W'(HDR_BYTES);
	assign pidx_nxt  = k_nxt - CNT_W'(HDR_BYTES);
	assign pay_raddr = pay_addr(f_slot_q, pidx_nxt[PAY_IDX_W-1:0]);
	assign meta_raddr = s_q;

	always_comb begin
		unique case (k_q)
			CNT_W'(0): fbyte = own_addr_q;
			CNT_W'(1): fbyte = f_dst_q;
			CNT_W'(2): fbyte = 8'(f_type_q);
			CNT_W'(3): fbyte = f_seq_q;
			CNT_W'(4): fbyte = 8'(f_len_q);
			default: begin
				unique case (f_src_q)
					SRC_RAM: fbyte = pay_rdata;
					SRC_OWN: fbyte = own_addr_q;
					default: fbyte = (pidx < CNT_W'(STAGE_DEPTH))
						? stage_q[pidx[STAGE_W-1:0]] : 8'd0;
				endcase
			end
		endcase
	end

	assign fend = (k_q == CNT_W'(HDR_BYTES - 1) + CNT_W'(f_len_q));

	always_comb begin
		if (state_q == ST_FRAME) begin
			gen_res.ev        = EV_BYTE;
			gen_res.data      = fbyte;
			gen_res.slot      = 2'(f_slot_q);
			gen_res.frame_end = fend;
		end else begin
			gen_res.ev        = ev_q;
			gen_res.data      = 8'd0;
			gen_res.slot      = 2'(ev_slot_q);
			gen_res.frame_end = 1'b0;
		end
	end

	always_comb begin
		meta_wr = '0;
		if (in_fire && (in_action == ACT_SEND) && any_free) begin
			meta_wr.en         = 1'b1;
			meta_wr.addr       = free_slot;
			meta_wr.data.dest  = in_dest;
			meta_wr.data.seq   = next_seq_q;
			meta_wr.data.len   = len_sat;
			meta_wr.data.stamp = in_now;
			meta_wr.data.tries = 4'd0;
		end else if ((state_q == ST_META_CHK) && !walk_ack_q && valid_q[s_q] && timed_out
				&& (meta_rdata.tries < retry_lim_q)) begin
			meta_wr.en         = 1'b1;
			meta_wr.addr       = s_q;
			meta_wr.data       = meta_rdata;
			meta_wr.data.stamp = now_q;
			meta_wr.data.tries = meta_rdata.tries + 4'd1;
		end
	end

	// A send copies each staged byte into its slot as the byte goes out.
	always_comb begin
		pay_wr      = '0;
		pay_wr.addr = pay_addr(f_slot_q, pidx[PAY_IDX_W-1:0]);
		pay_wr.data = fbyte;
		pay_wr.en   = gen_fire && (state_q == ST_FRAME) && (f_src_q == SRC_STAGE)
			&& (k_q >= CNT_W'(HDR_BYTES));
	end

	always_ff @(posedge clk) begin
		if (in_fire && (in_action == ACT_STAGE)) begin
			stage_q[in_stage_idx] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			own_addr_q  <= 8'd0;
			gateway_q   <= 1'b0;
			bcast_q     <= 8'd255;
			timeout_q   <= 16'd2000;
			retry_lim_q <= 4'd3;
			next_seq_q  <= 8'd0;
			valid_q     <= '0;
			s_q         <= '0;
			walk_ack_q  <= 1'b0;
			k_q         <= '0;
			f_dst_q     <= 8'd0;
			f_type_q    <= FT_DATA;
			f_seq_q     <= 8'd0;
			f_len_q     <= '0;
			f_slot_q    <= '0;
			f_src_q     <= SRC_STAGE;
			post_ev_q   <= 1'b0;
			walk_q      <= 1'b0;
			ev_q        <= EV_BYTE;
			ev_slot_q   <= '0;
			now_q       <= 32'd0;
			rx_seq_q    <= 8'd0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_OWN_ADDR:  own_addr_q  <= cfg_data[7:0];
					REG_GATEWAY:   gateway_q   <= cfg_data[0];
					REG_BCAST:     bcast_q     <= cfg_data[7:0];
					REG_TIMEOUT:   timeout_q   <= cfg_data;
					REG_RETRY_LIM: retry_lim_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (push) begin
				out_q      <= pend_q;
				out_last_q <= (state_q == ST_FLUSH);
				out_v_q    <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			if (gen_fire) begin
				pend_q   <= gen_res;
				pend_v_q <= 1'b1;
				k_q      <= k_q + CNT_W'(1);
			end else if ((state_q == ST_FLUSH) && out_room) begin
				pend_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						now_q     <= in_now;
						rx_seq_q  <= in_seq;
						k_q       <= '0;
						post_ev_q <= 1'b0;
						walk_q    <= 1'b0;
						f_slot_q  <= '0;
						f_len_q   <= '0;
						f_src_q   <= SRC_STAGE;
						s_q       <= '0;
						unique case (in_action)
							ACT_SEND: begin
								if (!any_free) begin
									ev_q      <= EV_REFUSE;
									ev_slot_q <= '0;
									state_q   <= ST_EVENT;
								end else begin
									valid_q[free_slot] <= 1'b1;
									next_seq_q <= next_seq_q + 8'd1;
									f_dst_q    <= in_dest;
									f_type_q   <= FT_DATA;
									f_seq_q    <= next_seq_q;
									f_len_q    <= len_sat;
									f_slot_q   <= free_slot;
									post_ev_q  <= 1'b1;
									ev_q       <= EV_ACCEPT;
									ev_slot_q  <= free_slot;
									state_q    <= ST_FRAME;
								end
							end
							ACT_TICK: begin
								if (gateway_q) begin
									valid_q <= '0;
								end else begin
									walk_q     <= 1'b1;
									walk_ack_q <= 1'b0;
									state_q    <= ST_META_RD;
								end
							end
							ACT_RX: begin
								if (mine && gateway_q && (in_kind == FT_DATA)) begin
									f_dst_q  <= in_source;
									f_type_q <= FT_ACK;
									f_seq_q  <= in_seq;
									state_q  <= ST_FRAME;
								end else if (mine && gateway_q && (in_kind == FT_DISCOVER)) begin
									f_dst_q    <= in_source;
									f_type_q   <= FT_OFFER;
									f_seq_q    <= next_seq_q;
									f_len_q    <= LEN_W'(1);
									f_src_q    <= SRC_OWN;
									next_seq_q <= next_seq_q + 8'd1;
									state_q    <= ST_FRAME;
								end else if (in_kind == FT_ACK) begin
									walk_q     <= 1'b1;
									walk_ack_q <= 1'b1;
									state_q    <= ST_META_RD;
								end
							end
							ACT_ANNOUNCE: begin
								f_dst_q    <= bcast_q;
								f_type_q   <= FT_DISCOVER;
								f_seq_q    <= next_seq_q;
								next_seq_q <= next_seq_q + 8'd1;
								state_q    <= ST_FRAME;
							end
							default: ;
						endcase
					end
				end
				ST_META_RD: begin
					state_q <= ST_META_CHK;
				end
				ST_META_CHK: begin
					priority if (walk_ack_q && valid_q[s_q] && (meta_rdata.seq == rx_seq_q)) begin
						valid_q[s_q] <= 1'b0;
						ev_q         <= EV_ACKED;
						ev_slot_q    <= s_q;
						state_q      <= ST_EVENT;
					end else if (!walk_ack_q && valid_q[s_q] && timed_out) begin
						if (meta_rdata.tries < retry_lim_q) begin
							f_dst_q  <= meta_rdata.dest;
							f_type_q <= FT_DATA;
							f_seq_q  <= meta_rdata.seq;
							f_len_q  <= meta_rdata.len;
							f_slot_q <= s_q;
							f_src_q  <= SRC_RAM;
							k_q      <= '0;
							state_q  <= ST_FRAME;
						end else begin
							valid_q[s_q] <= 1'b0;
							ev_q         <= EV_GIVEUP;
							ev_slot_q    <= s_q;
							state_q      <= ST_EVENT;
						end
					end else begin
						if (last_slot) begin
							state_q <= ST_FLUSH;
						end else begin
							s_q     <= s_q + SLOT_W'(1);
							state_q <= ST_META_RD;
						end
					end
				end
				ST_FRAME: begin
					if (gen_fire && fend) begin
						priority if (post_ev_q) begin
							state_q <= ST_EVENT;
						end else if (walk_q && !last_slot) begin
							s_q     <= s_q + SLOT_W'(1);
							state_q <= ST_META_RD;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_EVENT: begin
					if (gen_fire) begin
						if (walk_q && !last_slot) begin
							s_q     <= s_q + SLOT_W'(1);
							state_q <= ST_META_RD;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_v_q || out_ready))
		else $error("held result overwritten before its transaction");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FLUSH) && (!pend_v_q || out_room)) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAME) |-> (k_q <= CNT_W'(HDR_BYTES - 1) + CNT_W'(f_len_q)))
		else $error("frame byte counter ran past the frame");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending result left behind at idle");

endmodule
`default_nettype wire

@@ rtl/ack_retransmit_slot_table.sv @@
// A send of L payload bytes gives L + 6 results, its frame bytes then its accept event; each result
// passes a pending register and then the output register, one result a cycle while the output is
// not stalled. A node-mode tick reads each slot's entry from the slot memory (read, then check state)
// before the results it emits. One item at a time: the input is ready again once the slot walk and
// the frame byte sequencer are done. Reset (arst_n low) clears all slots, the sequence counter,
// the output register and loads the register defaults; no memory clearing pass is needed.
`default_nettype none
module ack_retransmit_slot_table import ars_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// dest_addr, source_addr, seq_num, payload_len, payload_byte, stage_index, now_time
	input  wire  [79:0] s_axis_tdata,
	// action, frame_kind
	input  wire  [4:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// event_res, frame_byte, slot_index
	output logic [15:0] m_axis_tdata,
	// frame_end
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	meta_wr_t              meta_wr;
	logic [SLOT_W-1:0]     meta_raddr;
	slot_meta_t            meta_rdata;
	pay_wr_t               pay_wr;
	logic [PAY_ADDR_W-1:0] pay_raddr;
	logic [7:0]            pay_rdata;
	result_t               res;

	ars_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_action    (s_axis_tuser[2:0]),
		.in_dest      (s_axis_tdata[7:0]),
		.in_source    (s_axis_tdata[15:8]),
		.in_kind      (s_axis_tuser[4:3]),
		.in_seq       (s_axis_tdata[23:16]),
		.in_len       (s_axis_tdata[31:24]),
		.in_byte      (s_axis_tdata[39:32]),
		.in_stage_idx (s_axis_tdata[42:40]),
		.in_now       (s_axis_tdata[74:43]),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_res      (res),
		.out_last     (m_axis_tlast),
		.meta_wr      (meta_wr),
		.meta_raddr   (meta_raddr),
		.meta_rdata   (meta_rdata),
		.pay_wr       (pay_wr),
		.pay_raddr    (pay_raddr),
		.pay_rdata    (pay_rdata)
	);

	ars_meta_ram u_meta_ram (
		.clk   (clk),
		.wr    (meta_wr),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	ars_pay_ram u_pay_ram (
		.clk   (clk),
		.wr    (pay_wr),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	assign m_axis_tdata = {3'd0, res.slot, res.data, res.ev};
	assign m_axis_tuser = res.frame_end;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import ars_pkg::*;

	typedef struct {
		action_t    act;
		logic [7:0] dst;
		logic [7:0] src;
		ftype_t     kind;
		logic [7:0] seq;
		logic [7:0] plen;
		logic [7:0] pbyte;
		logic [2:0] sidx;
		logic [31:0] now;
	} link_item_t;

	typedef struct {
		event_t     ev;
		logic [7:0] fbyte;
		logic [1:0] slot;
		logic       fend;
		logic       last;
	} link_event_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	wire         s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [4:0]  s_axis_tuser = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 0;
	wire  [15:0] m_axis_tdata;
	wire         m_axis_tuser;
	wire         m_axis_tlast;
	logic        cfg_valid = 0;
	wire         cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ack_retransmit_slot_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predicted link-layer state.
	logic [7:0]  own_addr = 8'd0;
	logic        gw_mode = 1'b0;
	logic [7:0]  bcast_addr = 8'd255;
	logic [15:0] ack_tmo = 16'd2000;
	logic [3:0]  retry_lim = 4'd3;
	logic        tbl_valid [SLOTS];
	logic [7:0]  tbl_dest [SLOTS];
	logic [7:0]  tbl_seq [SLOTS];
	logic [3:0]  tbl_len [SLOTS];
	logic [31:0] tbl_stamp [SLOTS];
	logic [3:0]  tbl_tries [SLOTS];
	logic [7:0]  tbl_payload [SLOTS][MAX_PAYLOAD];
	logic [7:0]  staged [STAGE_DEPTH];
	logic [7:0]  seq_counter = 8'd0;

	link_event_t expected_events[$];
	link_item_t  pending_items[$];
	link_item_t  cur_item;
	int          errors = 0;
	int          items_sent = 0;
	int          events_seen = 0;
	int          cycles = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	bit          quiet = 0;
	logic [7:0]  gen_seq = 8'd0;
	logic [31:0] gen_now = 32'd0;

	initial begin
		for (int s = 0; s < SLOTS; s++)
			tbl_valid[s] = 1'b0;
	end

	function automatic void push_event(event_t ev, logic [7:0] b, logic [1:0] slot, logic fend);
		link_event_t e;
		e.ev = ev;
		e.fbyte = b;
		e.slot = slot;
		e.fend = fend;
		e.last = 1'b0;
		expected_events.push_back(e);
	endfunction

	function automatic void emit_frame(logic [7:0] dst, ftype_t ft, logic [7:0] seq,
			logic [7:0] pl [MAX_PAYLOAD], int len, logic [1:0] slot);
		push_event(EV_BYTE, own_addr, slot, 1'b0);
		push_event(EV_BYTE, dst, slot, 1'b0);
		push_event(EV_BYTE, 8'(ft), slot, 1'b0);
		push_event(EV_BYTE, seq, slot, 1'b0);
		push_event(EV_BYTE, 8'(len), slot, len == 0);
		for (int i = 0; i < len; i++)
			push_event(EV_BYTE, pl[i], slot, i + 1 == len);
	endfunction

	function automatic void predict_link(link_item_t it);
		int n_prior;
		int s;
		int len;
		logic [7:0] pl [MAX_PAYLOAD];
		logic mine;
		n_prior = expected_events.size();
		for (int i = 0; i < MAX_PAYLOAD; i++)
			pl[i] = 8'd0;
		case (it.act)
			ACT_STAGE: staged[it.sidx] = it.pbyte;
			ACT_SEND: begin
				s = 0;
				while (s < SLOTS && tbl_valid[s])
					s++;
				if (s == SLOTS) begin
					push_event(EV_REFUSE, 8'd0, 2'd0, 1'b0);
				end else begin
					len = (it.plen > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(it.plen);
					for (int i = 0; i < len; i++)
						tbl_payload[s][i] = staged[i];
					tbl_valid[s] = 1'b1;
					tbl_dest[s] = it.dst;
					tbl_seq[s] = seq_counter;
					seq_counter = seq_counter + 8'd1;
					tbl_len[s] = 4'(len);
					tbl_stamp[s] = it.now;
					tbl_tries[s] = 4'd0;
					emit_frame(it.dst, FT_DATA, tbl_seq[s], tbl_payload[s], len, 2'(s));
					push_event(EV_ACCEPT, 8'd0, 2'(s), 1'b0);
				end
			end
			ACT_TICK: begin
				for (s = 0; s < SLOTS; s++) begin
					if (tbl_valid[s]) begin
						if (gw_mode) begin
							tbl_valid[s] = 1'b0;
						end else if (32'(it.now - tbl_stamp[s]) > 32'(ack_tmo)) begin
							if (tbl_tries[s] < retry_lim) begin
								emit_frame(tbl_dest[s], FT_DATA, tbl_seq[s], tbl_payload[s],
									int'(tbl_len[s]), 2'(s));
								tbl_stamp[s] = it.now;
								tbl_tries[s] = tbl_tries[s] + 4'd1;
							end else begin
								tbl_valid[s] = 1'b0;
								push_event(EV_GIVEUP, 8'd0, 2'(s), 1'b0);
							end
						end
					end
				end
			end
			ACT_RX: begin
				mine = (it.dst == own_addr) || (it.dst == bcast_addr);
				if (mine && gw_mode && it.kind == FT_DATA) begin
					emit_frame(it.src, FT_ACK, it.seq, pl, 0, 2'd0);
				end else if (mine && gw_mode && it.kind == FT_DISCOVER) begin
					pl[0] = own_addr;
					emit_frame(it.src, FT_OFFER, seq_counter, pl, 1, 2'd0);
					seq_counter = seq_counter + 8'd1;
				end else if (it.kind == FT_ACK) begin
					for (s = 0; s < SLOTS; s++)
						if (tbl_valid[s] && tbl_seq[s] == it.seq) begin
							tbl_valid[s] = 1'b0;
							push_event(EV_ACKED, 8'd0, 2'(s), 1'b0);
						end
				end
			end
			ACT_ANNOUNCE: begin
				emit_frame(bcast_addr, FT_DISCOVER, seq_counter, pl, 0, 2'd0);
				seq_counter = seq_counter + 8'd1;
			end
			default: ;
		endcase
		if (expected_events.size() > n_prior)
			expected_events[expected_events.size() - 1].last = 1'b1;
	endfunction

	function automatic void apply_register(reg_idx_t idx, logic [15:0] val);
		case (idx)
			REG_OWN_ADDR:  own_addr = val[7:0];
			REG_GATEWAY:   gw_mode = val[0];
			REG_BCAST:     bcast_addr = val[7:0];
			REG_TIMEOUT:   ack_tmo = val;
			REG_RETRY_LIM: retry_lim = val[3:0];
			default: ;
		endcase
	endfunction

	// Driver: offers queued items, holding each until its transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_link(cur_item);
				items_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					s_axis_tdata <= {5'd0, cur_item.now, cur_item.sidx, cur_item.pbyte,
						cur_item.plen, cur_item.seq, cur_item.src, cur_item.dst};
					s_axis_tuser <= {cur_item.kind, cur_item.act};
					s_axis_tvalid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 16);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, each result checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		link_event_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				events_seen++;
				if (expected_events.size() == 0) begin
					$error("unexpected result transaction, data %h", m_axis_tdata);
					errors++;
				end else begin
					e = expected_events.pop_front();
					if (m_axis_tdata[2:0] !== e.ev) begin
						$error("event_res expected %0d got %0d", e.ev, m_axis_tdata[2:0]);
						errors++;
					end
					if (m_axis_tdata[10:3] !== e.fbyte) begin
						$error("frame_byte expected %0d got %0d", e.fbyte, m_axis_tdata[10:3]);
						errors++;
					end
					if (m_axis_tdata[12:11] !== e.slot) begin
						$error("slot_index expected %0d got %0d", e.slot, m_axis_tdata[12:11]);
						errors++;
					end
					if (m_axis_tuser !== e.fend) begin
						$error("frame_end expected %0d got %0d", e.fend, m_axis_tuser);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last expected %0d got %0d", e.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					rx_gap = $urandom_range(1, 16);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() > 0 || s_axis_tvalid || expected_events.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic link_item_t make_item(action_t act, logic [7:0] dst, logic [7:0] src,
			ftype_t kind, logic [7:0] seq, logic [7:0] plen, logic [7:0] pbyte,
			logic [2:0] sidx, logic [31:0] now);
		link_item_t it;
		it.act = act; it.dst = dst; it.src = src; it.kind = kind; it.seq = seq;
		it.plen = plen; it.pbyte = pbyte; it.sidx = sidx; it.now = now;
		return it;
	endfunction

	function automatic link_item_t random_item();
		link_item_t it;
		int r;
		it = make_item(ACT_STAGE, 8'($urandom), 8'($urandom), ftype_t'($urandom),
			8'($urandom), 8'($urandom_range(0, 12)), 8'($urandom), 3'($urandom), 32'd0);
		if ($urandom_range(0, 9) == 0)
			it.plen = 8'($urandom);
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			gen_now = $urandom;
		else
			gen_now = gen_now + $urandom_range(0, 3000);
		it.now = gen_now;
		if (r < 18) begin
			it.act = ACT_STAGE;
		end else if (r < 43) begin
			it.act = ACT_SEND;
			gen_seq++;
		end else if (r < 66) begin
			it.act = ACT_TICK;
		end else if (r < 92) begin
			it.act = ACT_RX;
			case ($urandom_range(0, 3))
				0: it.dst = own_addr;
				1: it.dst = bcast_addr;
				default: ;
			endcase
			if ($urandom_range(0, 2) != 0)
				it.seq = gen_seq - 8'($urandom_range(1, 6));
		end else if (r < 97) begin
			it.act = ACT_ANNOUNCE;
			gen_seq++;
		end else begin
			it.act = action_t'($urandom_range(5, 7));
		end
		return it;
	endfunction

	initial begin
		logic [15:0] phase_cfg [4][5];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under reset defaults: fill staging, use and overflow the table.
		for (int i = 0; i < STAGE_DEPTH; i++)
			pending_items.push_back(make_item(ACT_STAGE, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0,
				(i % 2) ? 8'hFF : 8'(i * 37), 3'(i), 32'd0));
		pending_items.push_back(make_item(ACT_SEND, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_SEND, 8'hFF, 8'd0, FT_DATA, 8'd0, 8'd8, 8'd0,
			3'd0, 32'd10));
		pending_items.push_back(make_item(ACT_SEND, 8'd5, 8'd0, FT_DATA, 8'd0, 8'd255, 8'd0,
			3'd0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(ACT_SEND, 8'd9, 8'd0, FT_DATA, 8'd0, 8'd3, 8'd0,
			3'd0, 32'd20));
		pending_items.push_back(make_item(ACT_SEND, 8'd9, 8'd0, FT_DATA, 8'd0, 8'd3, 8'd0,
			3'd0, 32'd20));
		pending_items.push_back(make_item(ACT_RX, 8'd77, 8'd3, FT_ACK, 8'd1, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_RX, 8'd77, 8'd3, FT_ACK, 8'd200, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_TICK, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd2021));
		pending_items.push_back(make_item(ACT_TICK, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd2021));
		pending_items.push_back(make_item(ACT_RX, 8'd255, 8'd3, FT_OFFER, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_ANNOUNCE, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(action_t'(7), 8'hFF, 8'hFF, FT_OFFER, 8'hFF, 8'hFF,
			8'hFF, 3'd7, 32'hFFFF_FFFF));
		wait_idle();

		// Gateway answers, then frees the table on a tick.
		write_reg(REG_OWN_ADDR, 16'd42);
		write_reg(REG_GATEWAY, 16'd1);
		pending_items.push_back(make_item(ACT_RX, 8'd42, 8'd7, FT_DATA, 8'd99, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_RX, 8'd255, 8'd7, FT_DISCOVER, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_RX, 8'd13, 8'd7, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		pending_items.push_back(make_item(ACT_TICK, 8'd0, 8'd0, FT_DATA, 8'd0, 8'd0, 8'd0,
			3'd0, 32'd0));
		wait_idle();
		gen_seq = seq_counter;

		phase_cfg[0] = '{16'd0, 16'd0, 16'd255, 16'd0, 16'd15};
		phase_cfg[1] = '{16'd255, 16'd1, 16'd0, 16'd65535, 16'd0};
		phase_cfg[2] = '{16'd17, 16'd0, 16'd200, 16'd1500, 16'd1};
		phase_cfg[3] = '{16'd200, 16'd0, 16'd255, 16'd2000, 16'd3};
		for (int p = 0; p < 4; p++) begin
			for (int r = 0; r < 5; r++)
				write_reg(reg_idx_t'(r), phase_cfg[p][r]);
			quiet = (p == 3);
			for (int n = 0; n < 85; n++)
				pending_items.push_back(random_item());
			wait_idle();
		end

		$display("Covered %0d input transactions and %0d result transactions over several",
			items_sent, events_seen);
		$display("register settings, node and gateway roles included.");
		if (errors == 0 && expected_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
